/* hdl/hnrl_pkg.sv */
`timescale 1ns / 1ps

package hnrl_pkg;

    // Field and state widths
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned TIME_W    = 63;
    localparam int unsigned HASH_W    = 32;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned WIN_BYTES = 11;
    localparam int unsigned WIN_W     = WIN_BYTES * CHAR_W;
    localparam int unsigned KW_COUNT  = 12;
    localparam int unsigned ENTRY_W   = HASH_W + TIME_W;

    // FNV-1a constants
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    localparam logic [LEN_W-1:0] LEN_MAX       = 4'd15;
    localparam logic [LEN_W-1:0] LEN_TABLE_MIN = 4'd10;

    localparam logic [CNT_W-1:0] MIN_INTERVAL_RST = 32'd160000;

    typedef enum logic [1:0] {
        OUT_EXECUTED  = 2'd0,
        OUT_THROTTLED = 2'd1,
        OUT_BYPASSED  = 2'd2,
        OUT_EMPTY     = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        KIND_EMPTY  = 2'd0,
        KIND_BYPASS = 2'd1,
        KIND_CHECK  = 2'd2
    } t_kind;

    // One finished name on its way to the table
    typedef struct packed {
        t_kind               kind;
        logic [HASH_W-1:0]   hash;
        logic [TIME_W-1:0]   now;
    } t_term;

    typedef struct packed {
        logic                allowed;
        t_outcome            outcome;
        logic [HASH_W-1:0]   hash;
        logic [CNT_W-1:0]    skipped;
        logic [CNT_W-1:0]    executed;
        logic [CNT_W-1:0]    bypassed;
    } t_result;

    // Keywords, right aligned: the last character sits in the low byte,
    // matching the newest byte of the window.
    localparam logic [WIN_W-1:0] KW_TEXT [KW_COUNT] = '{
        "OnUpdate", "OnEvent", "OnLoad", "OnShow", "OnHide", "OnDragStart",
        "OnDragStop", "OnMouseDown", "OnMouseUp", "OnEnter", "OnLeave", "OnClick"
    };
    localparam int unsigned KW_LEN [KW_COUNT] = '{8, 7, 6, 6, 6, 11, 10, 11, 9, 7, 7, 7};

    // True when the window ends with one of the keywords
    function automatic logic kw_hit(input logic [WIN_W-1:0] win);
        logic             hit;
        logic [WIN_W-1:0] mask;
        hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            mask = (WIN_W'(1) << (CHAR_W * KW_LEN[k])) - WIN_W'(1);
            if (((win ^ KW_TEXT[k]) & mask) == '0) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

/* hdl/hnrl_in_if.sv */
`timescale 1ns / 1ps

interface hnrl_in_if;
    import hnrl_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   char_code;
    logic [TIME_W-1:0]   now_ticks;

    modport source (output valid, char_code, now_ticks, input ready);
    modport sink   (input valid, char_code, now_ticks, output ready);
endinterface

/* hdl/hnrl_out_if.sv */
`timescale 1ns / 1ps

interface hnrl_out_if;
    import hnrl_pkg::*;

    logic                valid;
    logic                ready;
    logic                allowed;
    logic [1:0]          outcome;
    logic [HASH_W-1:0]   name_hash;
    logic [CNT_W-1:0]    skipped_count;
    logic [CNT_W-1:0]    executed_count;
    logic [CNT_W-1:0]    bypassed_count;

    modport source (output valid, allowed, outcome, name_hash, skipped_count,
                    executed_count, bypassed_count, input ready);
    modport sink   (input valid, allowed, outcome, name_hash, skipped_count,
                    executed_count, bypassed_count, output ready);
endinterface

/* hdl/hnrl_ram.sv */
`timescale 1ns / 1ps

module hnrl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

/* hdl/hnrl_name.sv */
`timescale 1ns / 1ps

module hnrl_name (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [hnrl_pkg::CHAR_W-1:0] i_char,
    input  logic [hnrl_pkg::TIME_W-1:0] i_now,
    output logic                        o_term,
    output hnrl_pkg::t_term             o_term_data
);
    import hnrl_pkg::*;

    logic [HASH_W-1:0] r_hash;
    logic [LEN_W-1:0]  r_len;
    logic [WIN_W-1:0]  r_window;
    logic              r_kw;

    logic              w_char_nz;
    logic [HASH_W-1:0] n_hash;
    logic [WIN_W-1:0]  n_window;

    assign w_char_nz = (i_char != '0);
    assign n_hash    = (r_hash ^ HASH_W'(i_char)) * FNV_PRIME;
    assign n_window  = {r_window[WIN_W-CHAR_W-1:0], i_char};

    // Fold bytes into the name state; clear it on the terminator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= FNV_BASIS;
            r_len    <= '0;
            r_window <= '0;
            r_kw     <= 1'b0;
        end else if (i_accept) begin
            if (w_char_nz) begin
                r_hash   <= n_hash;
                r_len    <= (r_len == LEN_MAX) ? r_len : r_len + LEN_W'(1);
                r_window <= n_window;
                r_kw     <= r_kw | kw_hit(n_window);
            end else begin
                r_hash   <= FNV_BASIS;
                r_len    <= '0;
                r_window <= '0;
                r_kw     <= 1'b0;
            end
        end
    end

    // Classify the finished name
    assign o_term = i_accept && !w_char_nz;

    always_comb begin
        o_term_data.hash = r_hash;
        o_term_data.now  = i_now;
        if (r_len == '0) begin
            o_term_data.kind = KIND_EMPTY;
        end else if (r_kw || (r_len < LEN_TABLE_MIN)) begin
            o_term_data.kind = KIND_BYPASS;
        end else begin
            o_term_data.kind = KIND_CHECK;
        end
    end
endmodule

/* hdl/hnrl_slot.sv */
`timescale 1ns / 1ps

module hnrl_slot #(
    parameter int unsigned TABLE_DEPTH = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_term,
    input  hnrl_pkg::t_term                i_term_data,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    output logic                           o_valid,
    output hnrl_pkg::t_term                o_data,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_slot
);
    import hnrl_pkg::*;

    localparam int unsigned       ADDR_W     = $clog2(TABLE_DEPTH);
    localparam logic [63:0]       RECIP_FULL = 64'h1_0000_0000 / 64'(TABLE_DEPTH);
    localparam logic [HASH_W-1:0] RECIP      = RECIP_FULL[HASH_W-1:0];
    localparam logic [HASH_W-1:0] DEPTH_W    = HASH_W'(TABLE_DEPTH);

    logic               r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_term              r_s1_data, r_s2_data, r_s3_data, r_s4_data;
    logic [HASH_W-1:0]  r_s2_q;
    logic [HASH_W-1:0]  r_s3_qd;
    logic [ADDR_W-1:0]  r_s4_slot;

    logic [2*HASH_W-1:0] w_prod;
    logic [HASH_W-1:0]   w_qd;
    logic [HASH_W-1:0]   w_rem;
    logic [HASH_W-1:0]   w_fold;

    // Quotient estimate, at most one short of hash / depth
    assign w_prod = {{HASH_W{1'b0}}, r_s1_data.hash} * {{HASH_W{1'b0}}, RECIP};
    assign w_qd   = r_s2_q * DEPTH_W;
    // Remainder below twice the depth: one correction
    assign w_rem  = r_s3_data.hash - r_s3_qd;
    assign w_fold = (w_rem >= DEPTH_W) ? (w_rem - DEPTH_W) : w_rem;

    assign o_rd_addr = w_fold[ADDR_W-1:0];

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_term;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_data <= i_term_data;
            r_s2_data <= r_s1_data;
            r_s2_q    <= w_prod[2*HASH_W-1:HASH_W];
            r_s3_data <= r_s2_data;
            r_s3_qd   <= w_qd;
            r_s4_data <= r_s3_data;
            r_s4_slot <= w_fold[ADDR_W-1:0];
        end
    end

    assign o_valid = r_s4_valid;
    assign o_data  = r_s4_data;
    assign o_slot  = r_s4_slot;
endmodule

/* hdl/hnrl_decide.sv */
`timescale 1ns / 1ps

module hnrl_decide #(
    parameter int unsigned TABLE_DEPTH = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [hnrl_pkg::CNT_W-1:0]     i_min_interval,
    input  logic                           i_valid,
    input  hnrl_pkg::t_term                i_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_slot,
    input  logic [hnrl_pkg::ENTRY_W-1:0]   i_rd_data,
    output logic                           o_adv,
    output logic                           o_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_wr_addr,
    output logic [hnrl_pkg::ENTRY_W-1:0]   o_wr_data,
    hnrl_out_if.source                     o_rsp
);
    import hnrl_pkg::*;

    logic             r_out_valid;
    t_result          r_out;
    logic             r_skid_valid;
    t_result          r_skid;
    logic [CNT_W-1:0] r_skip_total, r_run_total, r_bypass_total;

    logic [CNT_W-1:0]  n_skip_total, n_run_total, n_bypass_total;
    logic [HASH_W-1:0] w_tag;
    logic [TIME_W-1:0] w_last;
    logic [TIME_W:0]   w_limit;
    logic              w_throttle;
    logic              w_fire;
    t_result           w_res;

    // Freeze the pipeline while a result waits in the skid stage
    assign o_adv  = !r_skid_valid;
    assign w_fire = i_valid && !r_skid_valid;

    // Tag compare and interval check; now < last + min covers time going back
    assign w_tag      = i_rd_data[ENTRY_W-1:TIME_W];
    assign w_last     = i_rd_data[TIME_W-1:0];
    assign w_limit    = {1'b0, w_last} + (TIME_W+1)'(i_min_interval);
    assign w_throttle = (w_tag == i_data.hash) && ({1'b0, i_data.now} < w_limit);

    // Decide and bump the totals
    always_comb begin
        n_skip_total   = r_skip_total;
        n_run_total    = r_run_total;
        n_bypass_total = r_bypass_total;
        w_res.allowed  = 1'b1;
        w_res.outcome  = OUT_EMPTY;
        case (i_data.kind)
            KIND_EMPTY: begin
                w_res.allowed = 1'b1;
                w_res.outcome = OUT_EMPTY;
            end
            KIND_BYPASS: begin
                n_bypass_total = r_bypass_total + CNT_W'(1);
                w_res.allowed  = 1'b1;
                w_res.outcome  = OUT_BYPASSED;
            end
            KIND_CHECK: begin
                if (w_throttle) begin
                    n_skip_total  = r_skip_total + CNT_W'(1);
                    w_res.allowed = 1'b0;
                    w_res.outcome = OUT_THROTTLED;
                end else begin
                    n_run_total   = r_run_total + CNT_W'(1);
                    w_res.allowed = 1'b1;
                    w_res.outcome = OUT_EXECUTED;
                end
            end
            default: begin
                w_res.allowed = 1'b1;
                w_res.outcome = OUT_EMPTY;
            end
        endcase
        w_res.hash     = i_data.hash;
        w_res.skipped  = n_skip_total;
        w_res.executed = n_run_total;
        w_res.bypassed = n_bypass_total;
    end

    // Store hash and time on every allowed table check
    assign o_wr_en   = w_fire && (i_data.kind == KIND_CHECK) && !w_throttle;
    assign o_wr_addr = i_slot;
    assign o_wr_data = {i_data.hash, i_data.now};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_total   <= '0;
            r_run_total    <= '0;
            r_bypass_total <= '0;
        end else if (w_fire) begin
            r_skip_total   <= n_skip_total;
            r_run_total    <= n_run_total;
            r_bypass_total <= n_bypass_total;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_rsp.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_fire;
            end
        end else if (w_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_rsp.ready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_fire) begin
            r_skid <= w_res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.allowed        = r_out.allowed;
    assign o_rsp.outcome        = r_out.outcome;
    assign o_rsp.name_hash      = r_out.hash;
    assign o_rsp.skipped_count  = r_out.skipped;
    assign o_rsp.executed_count = r_out.executed;
    assign o_rsp.bypassed_count = r_out.bypassed;
endmodule

/* hdl/hashed_name_rate_limiter_core.sv */
`timescale 1ns / 1ps
// Per-name rate limiter. Name bytes arrive on i_req (char_code, now_ticks),
// one byte per request, a zero byte ending the name. Every terminator gives
// one result request on o_rsp: allowed, outcome, the FNV-1a name hash and the
// three running totals; other bytes give none.
// Throughput: one request per cycle, sustained, except while the table is cleared
// or a result waits in the skid stage. Three stages reduce the hash modulo
// TABLE_DEPTH and address the table, then one registered table read, then the
// decision lands in the output register. min_interval is to be written by the
// user through i_cfg_we / i_cfg_wdata only while the block is idle; unenforced.
// Reset: totals, name state and min_interval (160000) are set at once; then a
// clearing pass zeros the hash/time table, one entry per cycle over all
// TABLE_DEPTH entries, with i_req.ready low (configuration writes still taken).
// Stall: a held result waits in the output register; one more result goes
// to a skid stage, after which the pipeline and i_req.ready hold until the
// receiver takes a result.
module hashed_name_rate_limiter_core #(
    parameter int unsigned TABLE_DEPTH = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [hnrl_pkg::CNT_W-1:0] i_cfg_wdata,
    hnrl_in_if.sink                    i_req,
    hnrl_out_if.source                 o_rsp
);
    import hnrl_pkg::*;

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

    logic [CNT_W-1:0]  r_min_interval;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_adv;
    logic              w_accept;
    logic              w_term;
    t_term             w_term_data;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_s4_valid;
    t_term             w_s4_data;
    logic [ADDR_W-1:0] w_s4_slot;
    logic [ENTRY_W-1:0] w_rd_data;
    logic              w_dec_wr_en;
    logic [ADDR_W-1:0] w_dec_wr_addr;
    logic [ENTRY_W-1:0] w_dec_wr_data;
    logic              w_ram_wr_en;
    logic [ADDR_W-1:0] w_ram_wr_addr;
    logic [ENTRY_W-1:0] w_ram_wr_data;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= MIN_INTERVAL_RST;
        end else if (i_cfg_we) begin
            r_min_interval <= i_cfg_wdata;
        end
    end

    // Sweep the table to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign i_req.ready = !r_clearing && w_adv;
    assign w_accept    = i_req.valid && i_req.ready;

    hnrl_name u_name (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_char      (i_req.char_code),
        .i_now       (i_req.now_ticks),
        .o_term      (w_term),
        .o_term_data (w_term_data)
    );

    hnrl_slot #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_term      (w_term),
        .i_term_data (w_term_data),
        .o_rd_addr   (w_rd_addr),
        .o_valid     (w_s4_valid),
        .o_data      (w_s4_data),
        .o_slot      (w_s4_slot)
    );

    // Clearing pass owns the write port until it finishes
    assign w_ram_wr_en   = r_clearing || w_dec_wr_en;
    assign w_ram_wr_addr = r_clearing ? r_clr_addr : w_dec_wr_addr;
    assign w_ram_wr_data = r_clearing ? '0 : w_dec_wr_data;

    hnrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    hnrl_decide #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_decide (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_min_interval (r_min_interval),
        .i_valid        (w_s4_valid),
        .i_data         (w_s4_data),
        .i_slot         (w_s4_slot),
        .i_rd_data      (w_rd_data),
        .o_adv          (w_adv),
        .o_wr_en        (w_dec_wr_en),
        .o_wr_addr      (w_dec_wr_addr),
        .o_wr_data      (w_dec_wr_data),
        .o_rsp          (o_rsp)
    );
endmodule

/* dv/hashed_name_rate_limiter_core_tb.sv */
`timescale 1ns / 1ps

module hashed_name_rate_limiter_core_tb;
    import hnrl_pkg::*;

    localparam int unsigned TABLE_SLOTS     = 512;
    localparam int unsigned DRAIN_SLACK     = 12;
    localparam int unsigned WATCHDOG_CYCLES = 4000;
    localparam int unsigned PHASE_BYTES     = 400;

    typedef logic [CHAR_W-1:0] t_byte_q [$];

    // Mirror of the limiter: name state, hash/time table and totals
    class throttle_scoreboard;
        string             keywords[$];
        bit [CNT_W-1:0]    min_interval;
        bit [HASH_W-1:0]   hash_acc;
        bit [LEN_W-1:0]    name_len;
        bit [CHAR_W-1:0]   window[WIN_BYTES];
        bit                keyword_seen;
        bit [HASH_W-1:0]   slot_tags[TABLE_SLOTS];
        bit [TIME_W-1:0]   slot_times[TABLE_SLOTS];
        bit [CNT_W-1:0]    skipped;
        bit [CNT_W-1:0]    executed;
        bit [CNT_W-1:0]    bypassed;
        t_result           due_verdicts[$];
        int unsigned       errors;

        function new();
            keywords = '{"OnUpdate", "OnEvent", "OnLoad", "OnShow", "OnHide", "OnDragStart",
                         "OnDragStop", "OnMouseDown", "OnMouseUp", "OnEnter", "OnLeave",
                         "OnClick"};
            min_interval = MIN_INTERVAL_RST;
            hash_acc     = FNV_BASIS;
            errors       = 0;
        endfunction

        function void set_interval(input logic [CNT_W-1:0] value);
            min_interval = value;
        endfunction

        // Fold one accepted request into the name, or decide on a terminator
        function void take_char(input logic [CHAR_W-1:0] code, input logic [TIME_W-1:0] ticks);
            t_result          verdict;
            int unsigned      slot;
            int               klen;
            bit               same;
            bit               throttle;
            string            word;
            if (code != '0) begin
                hash_acc = (hash_acc ^ {24'd0, code}) * FNV_PRIME;
                if (name_len != LEN_MAX) begin
                    name_len++;
                end
                for (int i = 0; i < WIN_BYTES - 1; i++) begin
                    window[i] = window[i+1];
                end
                window[WIN_BYTES-1] = code;
                // Match the newest bytes against every keyword
                for (int k = 0; k < keywords.size(); k++) begin
                    word = keywords[k];
                    klen = word.len();
                    same = 1'b1;
                    for (int i = 0; i < klen; i++) begin
                        if (window[WIN_BYTES - klen + i] != word[i]) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        keyword_seen = 1'b1;
                    end
                end
                return;
            end

            verdict.hash = hash_acc;
            if (name_len == '0) begin
                verdict.allowed = 1'b1;
                verdict.outcome = OUT_EMPTY;
            end else if (keyword_seen || name_len < LEN_TABLE_MIN) begin
                bypassed++;
                verdict.allowed = 1'b1;
                verdict.outcome = OUT_BYPASSED;
            end else begin
                // Look up the slot; a zero tag after reset still counts as a match
                slot     = hash_acc % TABLE_SLOTS;
                throttle = 1'b0;
                if (slot_tags[slot] == hash_acc) begin
                    if (ticks < slot_times[slot]) begin
                        throttle = 1'b1;
                    end else if ((ticks - slot_times[slot]) < min_interval) begin
                        throttle = 1'b1;
                    end
                end else begin
                    slot_tags[slot] = hash_acc;
                end
                if (throttle) begin
                    skipped++;
                    verdict.allowed = 1'b0;
                    verdict.outcome = OUT_THROTTLED;
                end else begin
                    slot_times[slot] = ticks;
                    executed++;
                    verdict.allowed = 1'b1;
                    verdict.outcome = OUT_EXECUTED;
                end
            end
            verdict.skipped  = skipped;
            verdict.executed = executed;
            verdict.bypassed = bypassed;
            due_verdicts.push_back(verdict);

            // Start the next name from scratch
            hash_acc     = FNV_BASIS;
            name_len     = '0;
            keyword_seen = 1'b0;
            foreach (window[i]) begin
                window[i] = '0;
            end
        endfunction

        function void compare_field(input string field, input logic [63:0] want,
                                    input logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest pending verdict
        function void check_verdict(input t_result got);
            t_result want;
            if (due_verdicts.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual hash %0h outcome %0d",
                         $time, got.hash, got.outcome);
                errors++;
                return;
            end
            want = due_verdicts.pop_front();
            compare_field("allowed", want.allowed, got.allowed);
            compare_field("outcome", want.outcome, got.outcome);
            compare_field("name_hash", want.hash, got.hash);
            compare_field("skipped_count", want.skipped, got.skipped);
            compare_field("executed_count", want.executed, got.executed);
            compare_field("bypassed_count", want.bypassed, got.bypassed);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_wdata;

    hnrl_in_if  req_if ();
    hnrl_out_if rsp_if ();

    throttle_scoreboard verdicts = new();

    bit                sender_idles;
    bit                receiver_idles;
    int unsigned       hold_cycles_req;
    int unsigned       bytes_sent;
    logic [TIME_W-1:0] now_base;
    logic [63:0]       step_max;
    t_byte_q           name_pool[16];

    hashed_name_rate_limiter_core #(
        .TABLE_DEPTH(TABLE_SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_byte_q text_bytes(input string s);
        t_byte_q q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic logic [TIME_W-1:0] noise_ticks();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Advance the time base: mostly forward, sometimes back, rarely anywhere
    function automatic logic [TIME_W-1:0] next_stamp();
        int unsigned roll;
        logic [63:0] step;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            now_base = noise_ticks();
        end else if (roll < 8) begin
            now_base = now_base - TIME_W'($urandom_range(1, 5000));
        end else begin
            step     = {$urandom, $urandom} % (step_max + 64'd1);
            now_base = now_base + TIME_W'(step);
        end
        return now_base;
    endfunction

    // Offer one request and hold it until taken
    task automatic push_char(input logic [CHAR_W-1:0] code, input logic [TIME_W-1:0] ticks);
        int unsigned gap;
        if (sender_idles && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 3);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.char_code <= code;
        req_if.now_ticks <= ticks;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        verdicts.take_char(code, ticks);
        bytes_sent++;
    endtask

    task automatic send_name(input t_byte_q name, input logic [TIME_W-1:0] ticks);
        foreach (name[i]) begin
            push_char(name[i], noise_ticks());
        end
        push_char('0, ticks);
    endtask

    // Mostly well-formed names of every class, some near misses
    task automatic send_random_name();
        t_byte_q     name;
        int unsigned pick;
        int unsigned len;
        int unsigned idx;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            len = 0;
        end else if (pick < 20) begin
            len = $urandom_range(1, 9);
            repeat (len) name.push_back(CHAR_W'($urandom_range(1, 255)));
        end else if (pick < 32) begin
            repeat ($urandom_range(0, 4)) name.push_back(CHAR_W'($urandom_range(1, 255)));
            name = {name, text_bytes(verdicts.keywords[$urandom_range(0, 11)])};
            repeat ($urandom_range(0, 4)) name.push_back(CHAR_W'($urandom_range(1, 255)));
        end else if (pick < 38) begin
            // Break one letter of a keyword by flipping its case
            name = text_bytes(verdicts.keywords[$urandom_range(0, 11)]);
            idx  = $urandom_range(0, name.size() - 1);
            name[idx] = name[idx] ^ 8'h20;
            len = $urandom_range(10, 14);
            while (name.size() < len) begin
                name.push_back(CHAR_W'($urandom_range(1, 255)));
            end
        end else if (pick < 50) begin
            len = $urandom_range(10, 24);
            repeat (len) name.push_back(CHAR_W'($urandom_range(1, 255)));
        end else begin
            name = name_pool[$urandom_range(0, 15)];
        end
        send_name(name, next_stamp());
    endtask

    // Stop offering, wait for every pending verdict, then let the pipe empty
    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts.due_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [CNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        verdicts.set_interval(value);
    endtask

    // Result side: check, stall at random, count quiet cycles
    initial begin : rx_side
        t_result     seen;
        int unsigned gap_left;
        int unsigned hold_left;
        int unsigned quiet;
        bit          hold_taken;
        gap_left   = 0;
        hold_left  = 0;
        quiet      = 0;
        hold_taken = 1'b0;
        rsp_if.ready <= 1'b0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                seen.allowed  = rsp_if.allowed;
                seen.outcome  = t_outcome'(rsp_if.outcome);
                seen.hash     = rsp_if.name_hash;
                seen.skipped  = rsp_if.skipped_count;
                seen.executed = rsp_if.executed_count;
                seen.bypassed = rsp_if.bypassed_count;
                verdicts.check_verdict(seen);
            end
            if (!hold_taken && hold_cycles_req != 0) begin
                hold_left  = hold_cycles_req;
                hold_taken = 1'b1;
            end
            if (hold_left != 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (gap_left != 0) begin
                rsp_if.ready <= 1'b0;
                gap_left--;
            end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
                rsp_if.ready <= 1'b0;
                gap_left = $urandom_range(0, 2);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
        $display("hashed_name_rate_limiter_core test failed");
        $finish;
    end

    initial begin : tx_side
        logic [HASH_W-1:0] p_inv;
        logic [HASH_W-1:0] h_pre;
        logic [HASH_W-1:0] h_mid;
        logic [HASH_W-1:0] target;
        logic [15:0]       tail_pair [logic [HASH_W-1:0]];
        t_byte_q           zero_name;
        t_byte_q           long_name;
        bit                found;
        logic [CNT_W-1:0]  interval;
        int unsigned       goal;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        req_if.valid     <= 1'b0;
        req_if.char_code <= '0;
        req_if.now_ticks <= '0;
        sender_idles     = 1'b1;
        receiver_idles   = 1'b1;
        hold_cycles_req  = 0;
        bytes_sent       = 0;
        now_base         = '0;
        step_max         = 64'd700;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Find a long name whose hash is zero, so it hits a cleared tag.
        // Meet in the middle: fixed prefix plus two bytes forward, two bytes back.
        p_inv = FNV_PRIME;
        repeat (5) p_inv = p_inv * (32'd2 - FNV_PRIME * p_inv);
        found = 1'b0;
        for (int attempt = 0; attempt < 16 && !found; attempt++) begin
            zero_name = text_bytes("zhash");
            zero_name.push_back(CHAR_W'(8'h41 + attempt));
            h_pre = FNV_BASIS;
            foreach (zero_name[i]) begin
                h_pre = (h_pre ^ {24'd0, zero_name[i]}) * FNV_PRIME;
            end
            tail_pair.delete();
            for (int a = 1; a < 256; a++) begin
                for (int b = 1; b < 256; b++) begin
                    h_mid = (((h_pre ^ 32'(a)) * FNV_PRIME) ^ 32'(b)) * FNV_PRIME;
                    tail_pair[h_mid] = {8'(a), 8'(b)};
                end
            end
            for (int c = 1; c < 256 && !found; c++) begin
                for (int d = 1; d < 256 && !found; d++) begin
                    target = (32'(d) * p_inv) ^ 32'(c);
                    if (tail_pair.exists(target)) begin
                        zero_name.push_back(tail_pair[target][15:8]);
                        zero_name.push_back(tail_pair[target][7:0]);
                        zero_name.push_back(CHAR_W'(c));
                        zero_name.push_back(CHAR_W'(d));
                        found = 1'b1;
                    end
                end
            end
        end

        for (int i = 0; i < 16; i++) begin
            repeat ($urandom_range(10, 18)) name_pool[i].push_back(CHAR_W'($urandom_range(1, 255)));
        end
        repeat (20) long_name.push_back(8'hFF);

        // Directed names under the reset interval
        push_char('0, '0);
        send_name(text_bytes("abc"), TIME_W'(10));
        send_name(text_bytes("OnUpdate"), TIME_W'(20));
        if (found) begin
            send_name(zero_name, TIME_W'(5));
            send_name(zero_name, TIME_W'(160005));
        end
        send_name(text_bytes("xOnDragStopxx"), TIME_W'(30));
        send_name(text_bytes("zzOnMouseDownzz"), TIME_W'(35));
        send_name(text_bytes("OnEvenXtraLong"), TIME_W'(1000));
        send_name(text_bytes("ninechars"), TIME_W'(40));
        send_name(text_bytes("tencharsxy"), '0);
        send_name(long_name, '1);
        send_name(long_name, '0);
        send_name(long_name, '1);

        // Random phases, each under its own interval
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin interval = 32'd1000;        step_max = 64'd700;           end
                1: begin interval = '0;              step_max = 64'd3;             end
                2: begin interval = '1;              step_max = 64'h2_0000_0000;   end
                3: begin interval = $urandom;        step_max = {32'd0, interval} * 2; end
                default: begin
                    interval = MIN_INTERVAL_RST;
                    step_max = 64'd200000;
                end
            endcase
            sender_idles   = (p != 4);
            receiver_idles = (p != 4);
            settle();
            write_interval(interval);
            if (p == 0) begin
                // Hold off results while empty names pour in
                hold_cycles_req = 80;
                repeat (30) push_char('0, next_stamp());
            end
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal) begin
                send_random_name();
            end
        end

        settle();
        if (verdicts.errors == 0) begin
            $display("hashed_name_rate_limiter_core test passed");
        end else begin
            $display("hashed_name_rate_limiter_core test failed");
        end
        $finish;
    end

endmodule

/* hashed_name_rate_limiter_core.f */
hdl/hnrl_pkg.sv
hdl/hnrl_in_if.sv
hdl/hnrl_out_if.sv
hdl/hnrl_ram.sv
hdl/hnrl_name.sv
hdl/hnrl_slot.sv
hdl/hnrl_decide.sv
hdl/hashed_name_rate_limiter_core.sv
dv/hashed_name_rate_limiter_core_tb.sv
